// ----- rtl/kv_cache_attention_head_top_defines.svh -----
// Assertion macros shared by the attention head RTL.
// Each macro expects clk_i and rst_ni in the enclosing scope.
`ifndef KV_CACHE_ATTENTION_HEAD_TOP_DEFINES_SVH
`define KV_CACHE_ATTENTION_HEAD_TOP_DEFINES_SVH

// Same-cycle implication
`define KVAH_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kvah same-cycle check failed");

// Next-cycle implication
`define KVAH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kvah next-cycle check failed");

`endif

// ----- rtl/kvah_pkg.sv -----
// Shared types, constants and exp tables for the attention head.
// No dependencies.
package kvah_pkg;

  typedef enum logic [1:0] {
    OP_LOAD_Q = 2'd0,
    OP_LOAD_K = 2'd1,
    OP_LOAD_V = 2'd2,
    OP_RUN    = 2'd3
  } kvah_op_e;

  localparam logic [7:0] CFG_LAST_POS   = 8'd0;
  localparam logic [7:0] CFG_HEAD_SIZE  = 8'd1;
  localparam logic [7:0] CFG_GROUP_SIZE = 8'd2;
  localparam logic [7:0] CFG_SCALE      = 8'd3;

  localparam int ACC_W = 42;  // holds dot products and weighted value sums
  localparam int SUM_W = 25;  // weight sum, up to 256 * 2^16
  localparam int NUM_W = 42;  // divider numerator

  localparam logic [16:0] EXPI [16] = '{
    17'd65536, 17'd24109, 17'd8869, 17'd3263, 17'd1200, 17'd442, 17'd162, 17'd60,
    17'd22, 17'd8, 17'd3, 17'd1, 17'd0, 17'd0, 17'd0, 17'd0
  };
  localparam logic [16:0] EXPF [16] = '{
    17'd65536, 17'd61565, 17'd57835, 17'd54331, 17'd51039, 17'd47947, 17'd45042,
    17'd42313, 17'd39749, 17'd37341, 17'd35079, 17'd32953, 17'd30957, 17'd29081,
    17'd27319, 17'd25664
  };

  // Controller to datapath commands
  typedef struct packed {
    logic       start;
    logic       load;
    logic       rd_qk;
    logic       mul_qk;
    logic       acc_qk;
    logic       scale_lo;
    logic       scale_hi;
    logic       score_wr;
    logic       rd_w;
    logic       mul_w;
    logic       w_wr;
    logic       rd_wv;
    logic       mul_wv;
    logic       acc_wv;
    logic       div_start;
    logic       out_load;
    logic       acc_clr;
    logic       last;
    logic [7:0] pos;
    logic [5:0] elem;
  } kvah_cmd_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic div_busy;
    logic out_full;
  } kvah_sts_t;

endpackage

// ----- rtl/kvah_if.sv -----
// Channel interfaces: input items, result items and configuration writes.
// No dependencies.
interface kvah_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  cmd;
  logic        [7:0]  position;
  logic        [8:0]  lane;
  logic signed [15:0] sample;
  logic        [2:0]  head;
  modport source (output valid, cmd, position, lane, sample, head, input ready);
  modport sink (input valid, cmd, position, lane, sample, head, output ready);
endinterface

interface kvah_out_if;
  logic               valid;
  logic               ready;
  logic        [5:0]  element;
  logic signed [15:0] out_value;
  logic               last;
  modport source (output valid, element, out_value, last, input ready);
  modport sink (input valid, element, out_value, last, output ready);
endinterface

interface kvah_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/kvah_div.sv -----
// Restoring divider, one quotient bit per cycle, for the output normalization.
// Depends on kvah_pkg.
module kvah_div import kvah_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [SUM_W-1:0] den_i,
  output logic             busy_o,
  output logic [NUM_W-1:0] quo_o
);

  logic             busy_q;
  logic [5:0]       cnt_q;
  logic [NUM_W-1:0] n_q;
  logic [SUM_W-1:0] r_q, den_q;
  logic [SUM_W:0]   rs;
  logic             ge;

  // One trial subtraction per cycle
  assign rs = {r_q, n_q[NUM_W-1]};
  assign ge = rs >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= 6'(NUM_W - 1);
    end else if (busy_q) begin
      if (cnt_q == 6'd0) busy_q <= 1'b0;
      cnt_q <= cnt_q - 6'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      n_q <= {n_q[NUM_W-2:0], ge};
      r_q <= ge ? SUM_W'(rs - {1'b0, den_q}) : rs[SUM_W-1:0];
    end
  end

  assign busy_o = busy_q;
  assign quo_o  = n_q;

endmodule

// ----- rtl/kvah_dp.sv -----
// Datapath: query/key/value/score memories, multiply-accumulate, exp weights, output register.
// Depends on kvah_pkg and kvah_div.
module kvah_dp import kvah_pkg::*; #(
  parameter int MAX_SEQ      = 256,
  parameter int MAX_HEAD_LEN = 64,
  parameter int MAX_HEADS    = 8,
  parameter int KV_ROW_WIDTH = 512
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kvah_cmd_t          cmd_i,
  output kvah_sts_t          sts_o,
  input  logic [1:0]         in_cmd_i,
  input  logic [7:0]         in_position_i,
  input  logic [8:0]         in_lane_i,
  input  logic signed [15:0] in_sample_i,
  input  logic [2:0]         in_head_i,
  input  logic [6:0]         hs_i,
  input  logic [3:0]         group_i,
  input  logic [15:0]        scale_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic [5:0]         out_element_o,
  output logic signed [15:0] out_value_o,
  output logic               out_last_o
);

  localparam int QDEPTH   = MAX_HEADS * MAX_HEAD_LEN;
  localparam int KVDEPTH  = MAX_SEQ * KV_ROW_WIDTH;
  localparam int Q_AW     = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int KV_AW    = (KVDEPTH > 1) ? $clog2(KVDEPTH) : 1;
  localparam int S_AW     = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;

  logic [15:0]        query_mem [QDEPTH];
  logic [15:0]        key_mem   [KVDEPTH];
  logic [15:0]        value_mem [KVDEPTH];
  logic [31:0]        score_mem [MAX_SEQ];

  logic [10:0]        qbase_q, kvoff_q;
  logic signed [31:0] maxs_q;
  logic [SUM_W-1:0]   sum_q;
  logic signed [ACC_W-1:0] acc_q;
  logic [15:0]        q_rd_q, k_rd_q, v_rd_q;
  logic               q_ok_q, k_ok_q, v_ok_q;
  logic [31:0]        w_rd_q;
  logic signed [33:0] prod_q;
  logic [33:0]        ew_q;
  logic               ew_ok_q;
  logic [34:0]        sp_lo_q;
  logic signed [35:0] sp_hi_q;
  logic               neg_q;
  logic               out_full_q;
  logic [5:0]         out_elem_q;
  logic signed [15:0] out_val_q;
  logic               out_last_q;

  logic [2:0]         kv_head;
  logic [10:0]        qi, ko;
  logic               q_ok, k_ok;
  logic [Q_AW-1:0]    q_addr;
  logic [KV_AW-1:0]   kv_addr, ld_addr;
  logic [S_AW-1:0]    s_addr;
  logic               ld_kv_ok;
  logic signed [54:0] sc_full;
  logic signed [31:0] sc_new;
  logic [32:0]        dlt;
  logic [16:0]        w_new;
  logic [ACC_W-1:0]   mag;
  logic [NUM_W-1:0]   num;
  logic               div_busy;
  logic [NUM_W-1:0]   quo;
  logic signed [15:0] sat;

  // Key/value head index: count of group multiples not above head
  always_comb begin
    kv_head = '0;
    for (int k = 1; k < 8; k++) begin
      if (32'(k) * 32'(group_i) <= 32'(in_head_i)) kv_head = 3'(k);
    end
  end

  // Read addresses for the current position and element
  assign qi      = qbase_q + 11'(cmd_i.elem);
  assign ko      = kvoff_q + 11'(cmd_i.elem);
  assign q_ok    = 32'(qi) < QDEPTH;
  assign k_ok    = 32'(ko) < KV_ROW_WIDTH;
  assign q_addr  = Q_AW'(qi);
  assign kv_addr = KV_AW'(32'(cmd_i.pos) * KV_ROW_WIDTH + 32'(ko));
  assign s_addr  = S_AW'(cmd_i.pos);

  // Load addressing
  assign ld_kv_ok = (32'(in_position_i) < MAX_SEQ) && (32'(in_lane_i) < KV_ROW_WIDTH);
  assign ld_addr  = KV_AW'(32'(in_position_i) * KV_ROW_WIDTH + 32'(in_lane_i));

  // Query memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_cmd_i == OP_LOAD_Q && 32'(in_lane_i) < QDEPTH)
      query_mem[Q_AW'(in_lane_i)] <= in_sample_i;
    if (cmd_i.rd_qk) q_rd_q <= query_mem[q_addr];
  end

  // Key memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_cmd_i == OP_LOAD_K && ld_kv_ok) key_mem[ld_addr] <= in_sample_i;
    if (cmd_i.rd_qk) k_rd_q <= key_mem[kv_addr];
  end

  // Value memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && in_cmd_i == OP_LOAD_V && ld_kv_ok) value_mem[ld_addr] <= in_sample_i;
    if (cmd_i.rd_wv) v_rd_q <= value_mem[kv_addr];
  end

  // Score memory, holds scores and then weights
  always_ff @(posedge clk_i) begin
    if (cmd_i.score_wr) score_mem[s_addr] <= sc_new;
    else if (cmd_i.w_wr) score_mem[s_addr] <= {15'd0, w_new};
    if (cmd_i.rd_w || cmd_i.rd_wv) w_rd_q <= score_mem[s_addr];
  end

  // Scaled score: 38-bit dot times Q0.16 scale in two partial products
  assign sc_full = ($signed({{19{sp_hi_q[35]}}, sp_hi_q}) <<< 19)
                 + $signed({20'd0, sp_lo_q});
  assign sc_new  = $signed({{5{sc_full[54]}}, sc_full[54:28]});

  // Weight from distance to the maximum score
  assign dlt   = 33'($signed({maxs_q[31], maxs_q}) - $signed({w_rd_q[31], w_rd_q}));
  assign w_new = ew_ok_q ? 17'((ew_q + 34'd32768) >> 16) : 17'd0;

  // Magnitude with half-divisor rounding
  assign mag = acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
  assign num = NUM_W'(mag) + NUM_W'(sum_q >> 1);

  // Saturated signed result
  always_comb begin
    if (!neg_q) sat = (quo > NUM_W'(32767)) ? 16'sd32767 : $signed(quo[15:0]);
    else        sat = (quo > NUM_W'(32768)) ? -16'sd32768 : $signed(16'(-quo[15:0]));
  end

  // Arithmetic registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      qbase_q <= 11'(32'(in_head_i) * 32'(hs_i));
      kvoff_q <= 11'(32'(kv_head) * 32'(hs_i));
    end
    if (cmd_i.start) maxs_q <= 32'sh8000_0000;
    else if (cmd_i.score_wr && sc_new > maxs_q) maxs_q <= sc_new;
    if (cmd_i.start) sum_q <= '0;
    else if (cmd_i.w_wr) sum_q <= sum_q + SUM_W'(w_new);
    if (cmd_i.rd_qk) begin
      q_ok_q <= q_ok;
      k_ok_q <= k_ok;
    end
    if (cmd_i.rd_wv) v_ok_q <= k_ok;
    // Full-width signed products in the 34-bit context of prod_q
    if (cmd_i.mul_qk)
      prod_q <= (q_ok_q ? $signed(q_rd_q) : 16'sd0) * (k_ok_q ? $signed(k_rd_q) : 16'sd0);
    else if (cmd_i.mul_wv)
      prod_q <= $signed({1'b0, w_rd_q[16:0]}) * (v_ok_q ? $signed(v_rd_q) : 16'sd0);
    if (cmd_i.acc_clr) acc_q <= '0;
    else if (cmd_i.acc_qk || cmd_i.acc_wv) acc_q <= acc_q + ACC_W'(prod_q);
    if (cmd_i.scale_lo) sp_lo_q <= 35'(acc_q[18:0]) * 35'(scale_i);
    if (cmd_i.scale_hi) sp_hi_q <= $signed(acc_q[37:19]) * $signed({1'b0, scale_i});
    if (cmd_i.mul_w) begin
      ew_q    <= 34'(EXPI[dlt[15:12]]) * 34'(EXPF[dlt[11:8]]);
      ew_ok_q <= dlt[32:16] == 17'd0;
    end
    if (cmd_i.div_start) neg_q <= acc_q[ACC_W-1];
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_full_q <= 1'b0;
    else if (cmd_i.out_load) out_full_q <= 1'b1;
    else if (out_ready_i) out_full_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_elem_q <= cmd_i.elem;
      out_val_q  <= sat;
      out_last_q <= cmd_i.last;
    end
  end

  kvah_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (num),
    .den_i   (sum_q),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign sts_o.div_busy = div_busy;
  assign sts_o.out_full = out_full_q;
  assign out_valid_o    = out_full_q;
  assign out_element_o  = out_elem_q;
  assign out_value_o    = out_val_q;
  assign out_last_o     = out_last_q;

endmodule

// ----- rtl/kvah_ctrl.sv -----
// Controller: sequences score, weight and output passes over positions and elements.
// Depends on kvah_pkg and the assertion macro header.
`include "kv_cache_attention_head_top_defines.svh"
module kvah_ctrl import kvah_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_cmd_i,
  output logic       in_ready_o,
  input  logic [6:0] hs_i,
  input  logic [7:0] lastp_i,
  input  kvah_sts_t  sts_i,
  output kvah_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_SC_RD, S_SC_MUL, S_SC_ACC, S_SC_SLO, S_SC_SHI, S_SC_WR,
    S_W_RD, S_W_MUL, S_W_WR, S_O_RD, S_O_MUL, S_O_ACC, S_O_DST, S_O_DIV
  } state_e;

  state_e     state_q;
  logic [7:0] p_q;
  logic [5:0] j_q;
  logic       fire, last_j, last_p, out_go;

  assign fire   = in_valid_i && (state_q == S_IDLE);
  assign last_j = {1'b0, j_q} == (hs_i - 7'd1);
  assign last_p = p_q == lastp_i;
  assign out_go = (state_q == S_O_DIV) && !sts_i.div_busy && !sts_i.out_full;

  // Command decode
  always_comb begin
    cmd_o           = '0;
    cmd_o.pos       = p_q;
    cmd_o.elem      = j_q;
    cmd_o.last      = last_j;
    cmd_o.start     = fire && in_cmd_i == OP_RUN;
    cmd_o.load      = fire && in_cmd_i != OP_RUN;
    cmd_o.rd_qk     = state_q == S_SC_RD;
    cmd_o.mul_qk    = state_q == S_SC_MUL;
    cmd_o.acc_qk    = state_q == S_SC_ACC;
    cmd_o.scale_lo  = state_q == S_SC_SLO;
    cmd_o.scale_hi  = state_q == S_SC_SHI;
    cmd_o.score_wr  = state_q == S_SC_WR;
    cmd_o.rd_w      = state_q == S_W_RD;
    cmd_o.mul_w     = state_q == S_W_MUL;
    cmd_o.w_wr      = state_q == S_W_WR;
    cmd_o.rd_wv     = state_q == S_O_RD;
    cmd_o.mul_wv    = state_q == S_O_MUL;
    cmd_o.acc_wv    = state_q == S_O_ACC;
    cmd_o.div_start = state_q == S_O_DST;
    cmd_o.out_load  = out_go;
    cmd_o.acc_clr   = cmd_o.start || cmd_o.score_wr || out_go;
  end

  assign in_ready_o = state_q == S_IDLE;

  // State and loop counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      p_q     <= '0;
      j_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (fire && in_cmd_i == OP_RUN) begin
            state_q <= S_SC_RD;
            p_q     <= '0;
            j_q     <= '0;
          end
        end
        S_SC_RD:  state_q <= S_SC_MUL;
        S_SC_MUL: state_q <= S_SC_ACC;
        S_SC_ACC: begin
          if (last_j) begin
            j_q     <= '0;
            state_q <= S_SC_SLO;
          end else begin
            j_q     <= j_q + 6'd1;
            state_q <= S_SC_RD;
          end
        end
        S_SC_SLO: state_q <= S_SC_SHI;
        S_SC_SHI: state_q <= S_SC_WR;
        S_SC_WR: begin
          if (last_p) begin
            p_q     <= '0;
            state_q <= S_W_RD;
          end else begin
            p_q     <= p_q + 8'd1;
            state_q <= S_SC_RD;
          end
        end
        S_W_RD:  state_q <= S_W_MUL;
        S_W_MUL: state_q <= S_W_WR;
        S_W_WR: begin
          if (last_p) begin
            p_q     <= '0;
            state_q <= S_O_RD;
          end else begin
            p_q     <= p_q + 8'd1;
            state_q <= S_W_RD;
          end
        end
        S_O_RD:  state_q <= S_O_MUL;
        S_O_MUL: state_q <= S_O_ACC;
        S_O_ACC: begin
          if (last_p) state_q <= S_O_DST;
          else begin
            p_q     <= p_q + 8'd1;
            state_q <= S_O_RD;
          end
        end
        S_O_DST: state_q <= S_O_DIV;
        S_O_DIV: begin
          if (out_go) begin
            p_q <= '0;
            if (last_j) begin
              j_q     <= '0;
              state_q <= S_IDLE;
            end else begin
              j_q     <= j_q + 6'd1;
              state_q <= S_O_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `KVAH_ASSERT_SAME(a_out_slot_free, cmd_o.out_load, !sts_i.out_full)
  `KVAH_ASSERT_NEXT(a_div_starts, cmd_o.div_start, sts_i.div_busy)
  `KVAH_ASSERT_NEXT(a_last_ends_run, cmd_o.out_load && cmd_o.last, state_q == S_IDLE)
  `KVAH_ASSERT_SAME(a_pos_bound, state_q != S_IDLE, p_q <= lastp_i)

endmodule

// ----- rtl/kv_cache_attention_head_top.sv -----
// Attention head top level: configuration registers, controller and datapath.
// Depends on kvah_pkg, kvah_if, kvah_ctrl and kvah_dp.
//
// A load item is written to its memory in the cycle it is accepted. A run item
// makes a score pass over the positions and elements, a weight pass over the
// positions and an output pass for every element, with multiply-accumulate
// steps on single-port memory reads and a bit-serial divide for every output
// element; input is held off until the head's last result has been handed to
// the output register.
module kv_cache_attention_head_top import kvah_pkg::*; #(
  parameter int MAX_SEQ      = 256,
  parameter int MAX_HEAD_LEN = 64,
  parameter int MAX_HEADS    = 8,
  parameter int KV_ROW_WIDTH = 512
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  kvah_in_if.sink    in_ch,
  kvah_out_if.source out_ch,
  kvah_cfg_if.sink   cfg_ch
);

  logic [7:0]  last_pos_q;
  logic [6:0]  head_size_q;
  logic [3:0]  group_size_q;
  logic [15:0] scale_q;
  logic [6:0]  hs_eff;
  logic [3:0]  g_eff;
  logic [7:0]  lastp_eff;
  kvah_cmd_t   cmd;
  kvah_sts_t   sts;

  // Configuration register file
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pos_q   <= 8'd0;
      head_size_q  <= 7'd64;
      group_size_q <= 4'd1;
      scale_q      <= 16'd8192;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_LAST_POS:   last_pos_q   <= cfg_ch.data[7:0];
        CFG_HEAD_SIZE:  head_size_q  <= cfg_ch.data[6:0];
        CFG_GROUP_SIZE: group_size_q <= cfg_ch.data[3:0];
        CFG_SCALE:      scale_q      <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Effective run settings
  always_comb begin
    if (head_size_q == 7'd0) hs_eff = 7'd1;
    else if (32'(head_size_q) > MAX_HEAD_LEN) hs_eff = 7'(MAX_HEAD_LEN);
    else hs_eff = head_size_q;
    g_eff     = (group_size_q == 4'd0) ? 4'd1 : group_size_q;
    lastp_eff = (32'(last_pos_q) > MAX_SEQ - 1) ? 8'(MAX_SEQ - 1) : last_pos_q;
  end

  kvah_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_ch.valid),
    .in_cmd_i   (in_ch.cmd),
    .in_ready_o (in_ch.ready),
    .hs_i       (hs_eff),
    .lastp_i    (lastp_eff),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kvah_dp #(
    .MAX_SEQ      (MAX_SEQ),
    .MAX_HEAD_LEN (MAX_HEAD_LEN),
    .MAX_HEADS    (MAX_HEADS),
    .KV_ROW_WIDTH (KV_ROW_WIDTH)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .in_cmd_i      (in_ch.cmd),
    .in_position_i (in_ch.position),
    .in_lane_i     (in_ch.lane),
    .in_sample_i   (in_ch.sample),
    .in_head_i     (in_ch.head),
    .hs_i          (hs_eff),
    .group_i       (g_eff),
    .scale_i       (scale_q),
    .out_ready_i   (out_ch.ready),
    .out_valid_o   (out_ch.valid),
    .out_element_o (out_ch.element),
    .out_value_o   (out_ch.out_value),
    .out_last_o    (out_ch.last)
  );

endmodule
